[design/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define FPA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FPA_ASSERT(lbl, clk, rstn, prop, msg)
`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/fpa_pkg.sv]
// Package for the fixed-partition allocator: sizes, widths and codes.
// Depends on nothing; used by the interfaces and the allocator.
`timescale 1ns / 1ps
package fpa_pkg;
    // Table geometry.
    localparam int PARTITIONS = 16;
    localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CNT_W      = $clog2(PARTITIONS + 1);

    // Field widths of the words.
    localparam int MODE_W   = 2;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int GRANT_W  = 5;
    localparam int TOTAL_W  = 20;
    localparam int POLICY_W = 2;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Placement policies; any other code acts as best fit.
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;

    typedef logic [SIZE_W-1:0] size_t;
endpackage

[design/fpa_in_if.sv]
// Input channel of the allocator: valid/ready handshake with mode and size.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
interface fpa_in_if;
    logic                         valid;
    logic                         ready;
    logic [fpa_pkg::MODE_W-1:0]   mode;
    logic [fpa_pkg::SIZE_W-1:0]   size;

    modport source (output valid, output mode, output size, input ready);
    modport sink   (input valid, input mode, input size, output ready);
endinterface

[design/fpa_out_if.sv]
// Result channel of the allocator: valid/ready handshake with outcome and totals.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
interface fpa_out_if;
    logic                           valid;
    logic                           ready;
    logic [fpa_pkg::STATUS_W-1:0]   status;
    logic [fpa_pkg::SLOT_W-1:0]     slot_index;
    logic [fpa_pkg::SIZE_W-1:0]     leftover;
    logic [fpa_pkg::GRANT_W-1:0]    granted_count;
    logic [fpa_pkg::TOTAL_W-1:0]    fragmentation_total;
    logic [fpa_pkg::TOTAL_W-1:0]    memory_total;

    modport source (output valid, output status, output slot_index, output leftover,
                    output granted_count, output fragmentation_total,
                    output memory_total, input ready);
    modport sink   (input valid, input status, input slot_index, input leftover,
                    input granted_count, input fragmentation_total,
                    input memory_total, output ready);
endinterface

[design/fixed_partition_allocator.sv]
// Append, restart and clear items: idle, then done, where the result is loaded once the output is free.
// Request: idle, then scan, then done; with no partitions loaded it goes straight to done.
// The scan reads the sizes RAM one entry a cycle; a held result stalls the load in done.
// A new word is accepted from the cycle in which the result appears, even if unread.
// rst_n (async, active low) clears marks, count, totals and policy; sizes stay undefined.
// Depends on fpa_pkg, fpa_in_if, fpa_out_if, fpa_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fixed_partition_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          policy_we,
    input  logic [fpa_pkg::POLICY_W-1:0]  policy_wdata,
    fpa_in_if.sink                        req,
    fpa_out_if.source                     rsp
);
    localparam int CW = fpa_pkg::CNT_W;
    localparam int IW = fpa_pkg::IDX_W;
    localparam int SW = fpa_pkg::SIZE_W;
    localparam int TW = fpa_pkg::TOTAL_W;
    localparam int GW = fpa_pkg::GRANT_W;
    localparam int LW = fpa_pkg::SLOT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Control and bookkeeping state.
    logic [1:0]                        state_reg, state_next;
    logic [fpa_pkg::POLICY_W-1:0]      policy_reg;
    logic [fpa_pkg::MODE_W-1:0]        mode_reg, mode_next;
    fpa_pkg::size_t                    need_reg, need_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [GW-1:0]                     granted_reg, granted_next;
    logic [TW-1:0]                     waste_reg, waste_next;
    logic [TW-1:0]                     capacity_reg, capacity_next;
    logic [fpa_pkg::PARTITIONS-1:0]    taken_reg, taken_next;

    // Scan pipeline: issue stage and compare stage.
    logic                              issue_reg, issue_next;
    logic [IW-1:0]                     issue_idx_reg, issue_idx_next;
    logic                              pend_reg, pend_next;
    logic [IW-1:0]                     pend_idx_reg, pend_idx_next;
    logic                              found_reg, found_next;
    logic [IW-1:0]                     pick_reg, pick_next;
    fpa_pkg::size_t                    pick_size_reg, pick_size_next;

    // Result register.
    logic                              out_valid_reg, out_valid_next;
    logic [fpa_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [LW-1:0]                     slot_reg, slot_next;
    fpa_pkg::size_t                    left_reg, left_next;

    // RAM port signals.
    logic                              ram_we;
    logic                              ram_re;
    fpa_pkg::size_t                    ram_rdata;
    fpa_pkg::size_t                    left_calc;
    logic                              accept;
    logic                              load;
    logic                              fits;
    logic                              better;

    fpa_ram #(
        .WIDTH (SW),
        .DEPTH (fpa_pkg::PARTITIONS)
    ) u_sizes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (need_reg),
        .re    (ram_re),
        .raddr (issue_idx_reg),
        .rdata (ram_rdata)
    );

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign load      = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign ram_re    = (state_reg == S_SCAN) && issue_reg;
    assign ram_we    = load && (mode_reg == fpa_pkg::MODE_APPEND)
                       && (count_reg < CW'(fpa_pkg::PARTITIONS));
    assign left_calc = pick_size_reg - need_reg;

    // Fit test on the entry that the RAM returns this cycle.
    always_comb
    begin
        fits   = pend_reg && !taken_reg[pend_idx_reg] && (ram_rdata >= need_reg);
        better = 1'b0;
        if (fits)
        begin
            if (!found_reg)
            begin
                better = 1'b1;
            end
            else if (policy_reg == fpa_pkg::POL_WORST)
            begin
                better = (ram_rdata > pick_size_reg);
            end
            else if (policy_reg != fpa_pkg::POL_FIRST)
            begin
                better = (ram_rdata < pick_size_reg);
            end
        end
    end

    // Sequencer, scan and read-modify-write of the bookkeeping state.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        need_next      = need_reg;
        count_next     = count_reg;
        granted_next   = granted_reg;
        waste_next     = waste_reg;
        capacity_next  = capacity_reg;
        taken_next     = taken_reg;
        issue_next     = issue_reg;
        issue_idx_next = issue_idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = issue_idx_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_size_next = pick_size_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        slot_next      = slot_reg;
        left_next      = left_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next      = req.mode;
                    need_next      = req.size;
                    found_next     = 1'b0;
                    issue_idx_next = '0;
                    if ((req.mode == fpa_pkg::MODE_REQUEST) && (count_reg != '0))
                    begin
                        issue_next = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        issue_next = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one read per cycle; compare the entry read last cycle.
                pend_next = issue_reg;
                if (issue_reg)
                begin
                    if ((CW'(issue_idx_reg) + CW'(1)) == count_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + IW'(1);
                    end
                end
                if (better)
                begin
                    found_next     = 1'b1;
                    pick_next      = pend_idx_reg;
                    pick_size_next = ram_rdata;
                end
                if (!issue_reg && pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    status_next    = fpa_pkg::ST_OK;
                    slot_next      = '0;
                    left_next      = '0;
                    state_next     = S_IDLE;
                    case (mode_reg)
                        fpa_pkg::MODE_APPEND:
                        begin
                            if (count_reg >= CW'(fpa_pkg::PARTITIONS))
                            begin
                                status_next = fpa_pkg::ST_FULL;
                            end
                            else
                            begin
                                slot_next                     = LW'(count_reg[IW-1:0]);
                                taken_next[count_reg[IW-1:0]] = 1'b0;
                                count_next                    = count_reg + CW'(1);
                                capacity_next = capacity_reg + TW'(need_reg);
                            end
                        end
                        fpa_pkg::MODE_REQUEST:
                        begin
                            if (found_reg)
                            begin
                                slot_next           = LW'(pick_reg);
                                left_next           = left_calc;
                                taken_next[pick_reg] = 1'b1;
                                granted_next        = granted_reg + GW'(1);
                                waste_next          = waste_reg + TW'(left_calc);
                            end
                            else
                            begin
                                status_next = fpa_pkg::ST_NOFIT;
                            end
                        end
                        fpa_pkg::MODE_RESTART:
                        begin
                            taken_next   = '0;
                            granted_next = '0;
                            waste_next   = '0;
                        end
                        default:
                        begin
                            taken_next    = '0;
                            granted_next  = '0;
                            waste_next    = '0;
                            count_next    = '0;
                            capacity_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= fpa_pkg::POL_FIRST;
            count_reg     <= '0;
            granted_reg   <= '0;
            waste_reg     <= '0;
            capacity_reg  <= '0;
            taken_reg     <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (policy_we)
            begin
                policy_reg <= policy_wdata;
            end
            count_reg     <= count_next;
            granted_reg   <= granted_next;
            waste_reg     <= waste_next;
            capacity_reg  <= capacity_next;
            taken_reg     <= taken_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        need_reg      <= need_next;
        issue_idx_reg <= issue_idx_next;
        pend_idx_reg  <= pend_idx_next;
        pick_reg      <= pick_next;
        pick_size_reg <= pick_size_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        left_reg      <= left_next;
    end

    // Result word.
    assign rsp.valid               = out_valid_reg;
    assign rsp.status              = status_reg;
    assign rsp.slot_index          = slot_reg;
    assign rsp.leftover            = left_reg;
    assign rsp.granted_count       = granted_reg;
    assign rsp.fragmentation_total = waste_reg;
    assign rsp.memory_total        = capacity_reg;

    // The table never holds more partitions than it has slots.
    `FPA_ASSERT(a_count_range, clk, rst_n, count_reg <= CW'(fpa_pkg::PARTITIONS), "partition count overflow")
    // Every granted request holds exactly one taken mark.
    `FPA_ASSERT(a_marks_match, clk, rst_n, $countones(taken_reg) == 32'(granted_reg), "taken marks and grant count disagree")
    // The RAM is read only while a request scans the table.
    `FPA_ASSERT(a_read_in_scan, clk, rst_n, ram_re |-> (count_reg != '0), "read issued on empty table")
    // Loading a result always leaves a valid word at the output.
    `FPA_ASSERT(a_load_valid, clk, rst_n, load |=> (rsp.valid && (state_reg == S_IDLE)), "result not presented after load")
    // The table is written only by an append that has room.
    `FPA_ASSERT(a_write_append, clk, rst_n, ram_we |-> ((mode_reg == fpa_pkg::MODE_APPEND) && load), "unexpected table write")
endmodule

[design/fpa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module fpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule
